[hw/rtl/rlws_pkg.sv]
// Shared types, sizes and codes for the RTP loss window statistics block.
package rlws_pkg;

   // Number of cells in the sorted packet table.
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Configuration port.
   localparam int PADDR_W = 3;
   localparam logic [PADDR_W-1:0] ADDR_WINDOW = 3'd0;
   localparam logic [19:0] WINDOW_RESET = 20'd30000;

   // Request actions.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   // Cell operations.
   localparam logic [2:0] OP_HOLD = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_KILL = 3'd2;
   localparam logic [2:0] OP_COMPACT = 3'd3;
   localparam logic [2:0] OP_ROTATE = 3'd4;

   // One table entry.
   typedef struct packed {
      logic        valid;
      logic [15:0] seq;
      logic [31:0] media;
      logic [31:0] arrival;
   } entry_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic [2:0]  op;
      entry_type   fresh;
      logic [31:0] limit;
      logic        expire_en;
   } ctrl_type;

endpackage

[hw/rtl/rtp_loss_window_statistics_top.sv]
// Top level of the RTP loss window statistics block.
//
// Requests enter on start while busy is low. An insert request (action 0)
// places the packet into a sorted chain of cells in the accepting cycle and
// returns busy low again at once, so inserts run at one per cycle and give
// no result. A full table drops the packet and sets the sticky overflow flag.
// A compute request (action 1) raises busy and walks the chain: it marks
// expired cells, closes the holes by shifting the chain down until valid
// cells form a prefix, rotates the ring once around past cell zero to gather
// the statistics, and then forms them. The result shows on the rsp_ ports
// for one cycle with rsp_strobe high; busy is already low.
// The receiver cannot stall, so nothing is held back. The user must write
// window_ms over the APB port only while idle; the block itself does not
// enforce this. Reset empties the table, clears the kept statistics and
// flags, and loads the default window of 30000 ms.
module rtp_loss_window_statistics_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [15:0]                  req_seq_number,
   input  logic [31:0]                  req_media_timestamp,
   input  logic [31:0]                  req_time_ms,
   output logic                         rsp_strobe,
   output logic [6:0]                   rsp_entry_count,
   output logic [15:0]                  rsp_min_seq,
   output logic [15:0]                  rsp_max_seq,
   output logic signed [17:0]           rsp_lost_count,
   output logic [15:0]                  rsp_longest_gap,
   output logic signed [32:0]           rsp_span_ticks,
   output logic [31:0]                  rsp_newest_media_time,
   output logic                         rsp_overflowed,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rlws_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import rlws_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MARK = 3'd1;
   localparam logic [2:0] ST_COMPACT = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [19:0] window_ff;
   logic [31:0] limit_ff;
   logic        expire_en_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] count_ff;
   logic [15:0] prev_ff, gap_acc_ff, min_acc_ff;
   logic [31:0] first_media_ff, last_media_ff;
   logic [15:0] last_min_ff, last_max_ff, last_gap_ff;
   logic [17:0] last_lost_ff;
   logic [31:0] newest_ff;
   logic        overflow_ff;
   logic        strobe_ff;
   logic [6:0]  count_out_ff;
   logic [32:0] span_ff;

   ctrl_type  ctrl;
   entry_type cell_q [TABLE_DEPTH];
   logic      gt [TABLE_DEPTH];
   logic      hole [TABLE_DEPTH];
   logic [TABLE_DEPTH-2:0] hole_pair;
   logic      accept, full, compact_done;
   entry_type head;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign full = cell_q[TABLE_DEPTH-1].valid;
   assign head = cell_q[0];

   // Configuration port.
   assign pready = 1'b1;
   assign prdata = {12'd0, window_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (psel && penable && pwrite && (paddr == ADDR_WINDOW)) begin
         window_ff <= pwdata[19:0];
      end
   end

   // Command for the chain.
   always_comb begin
      ctrl.op = OP_HOLD;
      ctrl.fresh.valid = 1'b1;
      ctrl.fresh.seq = req_seq_number;
      ctrl.fresh.media = req_media_timestamp;
      ctrl.fresh.arrival = req_time_ms;
      ctrl.limit = limit_ff;
      ctrl.expire_en = expire_en_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_INSERT) && !full) begin
               ctrl.op = OP_INSERT;
            end
         end
         ST_MARK: ctrl.op = OP_KILL;
         ST_COMPACT: ctrl.op = OP_COMPACT;
         ST_SCAN: ctrl.op = OP_ROTATE;
         default: ctrl.op = OP_HOLD;
      endcase
   end

   // The chain of cells.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_g, left_h;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_g = 1'b0;
         assign left_h = 1'b0;
      end else begin : g_mid
         assign left_e = cell_q[i-1];
         assign left_g = gt[i-1];
         assign left_h = hole[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_e = (ctrl.op == OP_ROTATE) ? cell_q[0] : '0;
      end else begin : g_inner
         assign right_e = cell_q[i+1];
         assign hole_pair[i] = !cell_q[i].valid && cell_q[i+1].valid;
      end
      rlws_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_gt     (left_g),
         .left_hole   (left_h),
         .cur_entry   (cell_q[i]),
         .gt_out      (gt[i]),
         .hole_out    (hole[i])
      );
   end

   assign compact_done = ~|hole_pair;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_COMPUTE)) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: state_in = ST_COMPACT;
         ST_COMPACT: begin
            if (compact_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Expiry limit is taken when a compute request is accepted.
   always_ff @(posedge clock) begin
      if (accept && (req_action == ACT_COMPUTE)) begin
         limit_ff <= req_time_ms - {12'd0, window_ff};
         expire_en_ff <= (req_time_ms >= {12'd0, window_ff});
      end
   end

   // Newest media time and overflow flag follow insert requests.
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         overflow_ff <= 1'b0;
      end else if (accept && (req_action == ACT_INSERT)) begin
         if (full) begin
            overflow_ff <= 1'b1;
         end else if (req_media_timestamp > newest_ff) begin
            newest_ff <= req_media_timestamp;
         end
      end
   end

   // Statistics are gathered from cell zero while the ring rotates.
   always_ff @(posedge clock) begin
      if (state_ff == ST_COMPACT) begin
         idx_ff <= '0;
         count_ff <= '0;
         gap_acc_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + 1'b1;
         if (head.valid) begin
            count_ff <= count_ff + 1'b1;
            prev_ff <= head.seq;
            last_media_ff <= head.media;
            if (count_ff == '0) begin
               min_acc_ff <= head.seq;
               first_media_ff <= head.media;
            end else if ((head.seq > prev_ff) &&
                         ((head.seq - prev_ff - 16'd1) > gap_acc_ff)) begin
               gap_acc_ff <= head.seq - prev_ff - 16'd1;
            end
         end
      end
   end

   // Kept statistics; they stay as they are when the table is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_min_ff <= '0;
         last_max_ff <= '0;
         last_lost_ff <= '0;
         last_gap_ff <= '0;
      end else if ((state_ff == ST_DONE) && (count_ff != '0)) begin
         last_min_ff <= min_acc_ff;
         last_max_ff <= prev_ff;
         last_lost_ff <= {2'd0, prev_ff} - {2'd0, min_acc_ff} + 18'd1 - 18'(count_ff);
         last_gap_ff <= gap_acc_ff;
      end
   end

   // Result registers and strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         count_out_ff <= 7'(count_ff);
         if (count_ff != '0) begin
            span_ff <= {1'b0, last_media_ff} - {1'b0, first_media_ff};
         end else begin
            span_ff <= '0;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_entry_count = count_out_ff;
   assign rsp_min_seq = last_min_ff;
   assign rsp_max_seq = last_max_ff;
   assign rsp_lost_count = last_lost_ff;
   assign rsp_longest_gap = last_gap_ff;
   assign rsp_span_ticks = span_ff;
   assign rsp_newest_media_time = newest_ff;
   assign rsp_overflowed = overflow_ff;

   // The overflow flag never clears outside reset.
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared");

   // An insert into a full table sets the overflow flag.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_INSERT) && full) |=> overflow_ff)
      else $error("dropped insert did not set overflow");

   // A result strobe always follows the final statistics cycle.
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == ST_DONE)
      else $error("result strobe without a finished compute");

   // Valid cells form a prefix of the chain whenever the block is idle.
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> compact_done)
      else $error("hole in the table while idle");

endmodule

[hw/rtl/rlws_cell.sv]
// One cell of the sorted packet table chain.
module rlws_cell (
   input  logic               clock,
   input  logic               reset,
   input  rlws_pkg::ctrl_type  ctrl,
   input  rlws_pkg::entry_type left_entry,
   input  rlws_pkg::entry_type right_entry,
   input  logic               left_gt,
   input  logic               left_hole,
   output rlws_pkg::entry_type cur_entry,
   output logic               gt_out,
   output logic               hole_out
);
   import rlws_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // An empty cell sorts after every new entry; equal numbers stay ahead of it.
   assign gt_out = !entry_ff.valid || (entry_ff.seq > ctrl.fresh.seq);
   // A hole at or before this cell pulls the rest of the chain down by one.
   assign hole_out = left_hole || !entry_ff.valid;
   assign cur_entry = entry_ff;

   // Next contents of the cell.
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (gt_out) begin
               entry_in = left_gt ? left_entry : ctrl.fresh;
            end
         end
         OP_KILL: begin
            if (ctrl.expire_en && (entry_ff.arrival < ctrl.limit)) begin
               entry_in.valid = 1'b0;
            end
         end
         OP_COMPACT: begin
            if (hole_out) begin
               entry_in = right_entry;
            end
         end
         OP_ROTATE: begin
            entry_in = right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
